// File: rtl/core/mmiodec_pkg.sv
// Shared types and constants for the x86 MMIO instruction decode and apply block.
// Holds the item and result structs, phase enums and opcode constants.
// No dependencies.
`timescale 1ns / 1ps

package mmiodec_pkg;

  // default fetch limit in bytes
  localparam int unsigned MAX_FETCH = 16;

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 64;
  localparam int unsigned DataW = 64;
  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 4;
  localparam int unsigned LenW  = 5;
  localparam int unsigned ErrW  = 4;

  // opcodes and decode masks
  localparam logic [7:0] OP_MOV_STORE = 8'h89;
  localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
  localparam logic [7:0] OP_MOV_IMM   = 8'hC7;
  localparam logic [7:0] OP_ADD       = 8'h01;
  localparam logic [7:0] OP_OR        = 8'h09;
  localparam logic [7:0] OP_AND       = 8'h21;
  localparam logic [7:0] OP_XOR       = 8'h31;
  localparam logic [7:0] REX_HI       = 8'h40;
  localparam logic [7:0] REX_HI_MASK  = 8'hF0;
  localparam logic [7:0] REX_R_BIT    = 8'h04;
  localparam logic [7:0] MODRM_REG    = 8'h38;

  // kind of an incoming item
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_REG  = 2'd1,
    KIND_DEV  = 2'd2
  } kind_e;

  // action of a result
  typedef enum logic [2:0] {
    ACT_REG_READ  = 3'd0,
    ACT_DEV_READ  = 3'd1,
    ACT_DEV_WRITE = 3'd2,
    ACT_REG_WRITE = 3'd3,
    ACT_ERROR     = 3'd4
  } act_e;

  // error codes
  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 4'd0,
    ERR_BAD_LEN   = 4'd1,
    ERR_TRUNC     = 4'd2,
    ERR_NO_MODRM  = 4'd3,
    ERR_REG_DIRECT = 4'd4,
    ERR_NO_SIB    = 4'd5,
    ERR_OVERRUN   = 4'd6,
    ERR_C7_REG    = 4'd7,
    ERR_UNSUPP    = 4'd8
  } err_e;

  // byte parser phases
  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_OPCODE = 3'd1,
    PH_MODRM  = 3'd2,
    PH_SIB    = 3'd3,
    PH_TAIL   = 3'd4,
    PH_STOP   = 3'd5
  } parse_e;

  // execution phases
  typedef enum logic [2:0] {
    EX_IDLE      = 3'd0,
    EX_REG_STORE = 3'd1,
    EX_REG_RMW   = 3'd2,
    EX_DEV_LOAD  = 3'd3,
    EX_DEV_RMW   = 3'd4
  } exec_e;

  // one input item
  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   byte_value;
    logic               last_byte;
    logic [AddrW-1:0]   fault_address;
    logic [DataW-1:0]   data_value;
  } in_item_t;

  // one result item
  typedef struct packed {
    act_e               action;
    logic [RegW-1:0]    reg_index;
    logic [AddrW-1:0]   access_address;
    logic [WordW-1:0]   out_data;
    logic [LenW-1:0]    insn_length;
    err_e               error_code;
    logic               done_res;
  } res_t;

endpackage

// File: rtl/core/mmiodec_core.sv
// Decode and execute logic: byte parser, exec sequencer and result forming.
// Depends on mmiodec_pkg.
`timescale 1ns / 1ps

module mmiodec_core #(
  parameter int unsigned MaxFetch = mmiodec_pkg::MAX_FETCH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mmiodec_pkg::in_item_t item_i,
  input  logic                  fire_i,
  output logic                  res_valid_o,
  output mmiodec_pkg::res_t     res_o
);
  import mmiodec_pkg::*;

  localparam int unsigned CntW = $clog2(MaxFetch + 2);
  localparam int unsigned AeW  = $clog2(MaxFetch + 7);
  localparam logic [CntW-1:0] CntSat = CntW'(MaxFetch + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxFetch);

  parse_e           parse_q, parse_d;
  exec_e            exec_q, exec_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rex_q, rex_d;
  logic [7:0]       opc_q, opc_d;
  logic [7:0]       modrm_q, modrm_d;
  logic [3:0]       owed_q, owed_d;
  logic [AeW-1:0]   ae_q, ae_d;
  logic [WordW-1:0] imm_q, imm_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [WordW-1:0] src_q, src_d;
  err_e             ferr_q, ferr_d;

  function automatic logic is_prefix(input logic [7:0] b);
    return b == 8'h66 || b == 8'hF2 || b == 8'hF3 || b == 8'hF0 ||
           b == 8'h2E || b == 8'h3E || b == 8'h26 || b == 8'h64 ||
           b == 8'h65 || b == 8'h36;
  endfunction

  function automatic logic [2:0] disp_len(input logic [1:0] md, input logic [2:0] lo);
    logic [2:0] r;
    r = 3'd0;
    if (md == 2'd0 && lo == 3'd5) r = 3'd4;
    else if (md == 2'd1)         r = 3'd1;
    else if (md == 2'd2)         r = 3'd4;
    return r;
  endfunction

  // next state and result
  always_comb begin
    logic [7:0]       b;
    logic [WordW-1:0] v;
    logic [2:0]       disp;
    logic [3:0]       immlen;
    logic [AeW-1:0]   pos_ext;
    logic [AeW-1:0]   kdiff;
    logic             tail_start;
    logic [2:0]       tail_disp;
    logic [CntW-1:0]  len;
    parse_e           phase;
    err_e             err;
    logic [AeW:0]     lsum;
    logic [LenW-1:0]  cur_len;
    logic [RegW-1:0]  cur_reg;
    logic             supported;

    parse_d = parse_q;
    exec_d  = exec_q;
    cnt_d   = cnt_q;
    rex_d   = rex_q;
    opc_d   = opc_q;
    modrm_d = modrm_q;
    owed_d  = owed_q;
    ae_d    = ae_q;
    imm_d   = imm_q;
    addr_d  = addr_q;
    src_d   = src_q;
    ferr_d  = ferr_q;

    b          = item_i.byte_value;
    v          = item_i.data_value[WordW-1:0];
    pos_ext    = AeW'(cnt_q);
    tail_start = 1'b0;
    tail_disp  = 3'd0;
    len        = '0;
    phase      = PH_PREFIX;
    err        = ERR_NONE;
    disp       = 3'd0;
    kdiff      = '0;
    supported  = 1'b0;

    res_valid_o = 1'b0;
    res_o       = '0;

    if (item_i.kind == KIND_BYTE && exec_q == EX_IDLE) begin
      addr_d = item_i.fault_address;
      // first byte of an instruction clears the decode fields
      if (cnt_q == '0) begin
        rex_d   = 1'b0;
        opc_d   = '0;
        modrm_d = '0;
        ae_d    = '0;
        imm_d   = '0;
        owed_d  = '0;
        ferr_d  = ERR_NONE;
        parse_d = PH_PREFIX;
      end
      if (cnt_q < CntSat) cnt_d = cnt_q + 1'b1;

      // byte parser
      case (parse_d)
        PH_PREFIX: begin
          if (!is_prefix(b)) begin
            if ((b & REX_HI_MASK) == REX_HI) begin
              rex_d   = (b & REX_R_BIT) != 8'h00;
              parse_d = PH_OPCODE;
            end else begin
              opc_d   = b;
              parse_d = PH_MODRM;
            end
          end
        end
        PH_OPCODE: begin
          opc_d   = b;
          parse_d = PH_MODRM;
        end
        PH_MODRM: begin
          modrm_d = b;
          if (b[7:6] == 2'd3) begin
            ferr_d  = ERR_REG_DIRECT;
            parse_d = PH_STOP;
          end else if (b[2:0] == 3'd4) begin
            parse_d = PH_SIB;
          end else begin
            tail_start = 1'b1;
            tail_disp  = disp_len(b[7:6], b[2:0]);
          end
        end
        PH_SIB: begin
          tail_start = 1'b1;
          tail_disp  = disp_len(modrm_d[7:6], b[2:0]);
        end
        PH_TAIL: begin
          if (owed_d != 4'd0) owed_d = owed_d - 4'd1;
          kdiff = pos_ext - ae_d;
          if (opc_d == OP_MOV_IMM && pos_ext >= ae_d && kdiff < AeW'(4))
            imm_d[{kdiff[1:0], 3'b000} +: 8] = imm_d[{kdiff[1:0], 3'b000} +: 8] | b;
        end
        default: ;
      endcase

      // addressing done: set end position and bytes owed
      immlen = (opc_d == OP_MOV_IMM) ? 4'd4 : 4'd0;
      disp   = tail_disp;
      if (tail_start) begin
        ae_d    = pos_ext + AeW'(1) + AeW'(disp);
        owed_d  = 4'(disp) + immlen;
        parse_d = PH_TAIL;
      end

      lsum    = (AeW+1)'(ae_d) + (AeW+1)'(immlen);
      cur_len = lsum[LenW-1:0];
      cur_reg = {rex_d, modrm_d[5:3]};

      if (item_i.last_byte) begin
        len   = cnt_d;
        phase = parse_d;
        supported = opc_d == OP_MOV_IMM || opc_d == OP_MOV_LOAD ||
                    opc_d == OP_MOV_STORE || opc_d == OP_ADD ||
                    opc_d == OP_OR || opc_d == OP_AND || opc_d == OP_XOR;
        // error checks in priority order
        if (len > CntMax)                                    err = ERR_BAD_LEN;
        else if (phase == PH_PREFIX || phase == PH_OPCODE)   err = ERR_TRUNC;
        else if (phase == PH_MODRM)                          err = ERR_NO_MODRM;
        else if (phase == PH_STOP)                           err = ferr_d;
        else if (phase == PH_SIB)                            err = ERR_NO_SIB;
        else if (owed_d != 4'd0)                             err = ERR_OVERRUN;
        else if (opc_d == OP_MOV_IMM && (modrm_d & MODRM_REG) != 8'h00)
                                                             err = ERR_C7_REG;
        else if (!supported)                                 err = ERR_UNSUPP;

        cnt_d   = '0;
        parse_d = PH_PREFIX;
        owed_d  = '0;
        ferr_d  = ERR_NONE;

        res_valid_o = 1'b1;
        if (err != ERR_NONE) begin
          res_o.action     = ACT_ERROR;
          res_o.error_code = err;
          res_o.done_res   = 1'b1;
        end else begin
          res_o.reg_index   = cur_reg;
          res_o.insn_length = cur_len;
          res_o.error_code  = ERR_NONE;
          if (opc_d == OP_MOV_IMM) begin
            res_o.action         = ACT_DEV_WRITE;
            res_o.access_address = addr_d;
            res_o.out_data       = imm_d;
            res_o.done_res       = 1'b1;
          end else if (opc_d == OP_MOV_LOAD) begin
            res_o.action         = ACT_DEV_READ;
            res_o.access_address = addr_d;
            exec_d               = EX_DEV_LOAD;
          end else begin
            res_o.action = ACT_REG_READ;
            exec_d       = (opc_d == OP_MOV_STORE) ? EX_REG_STORE : EX_REG_RMW;
          end
        end
      end
    end else begin
      // replies to earlier requests
      immlen  = (opc_q == OP_MOV_IMM) ? 4'd4 : 4'd0;
      lsum    = (AeW+1)'(ae_q) + (AeW+1)'(immlen);
      cur_len = lsum[LenW-1:0];
      cur_reg = {rex_q, modrm_q[5:3]};
      res_o.reg_index   = cur_reg;
      res_o.insn_length = cur_len;
      res_o.error_code  = ERR_NONE;
      if (item_i.kind == KIND_REG && exec_q == EX_REG_STORE) begin
        res_valid_o          = 1'b1;
        res_o.action         = ACT_DEV_WRITE;
        res_o.access_address = addr_q;
        res_o.out_data       = v;
        res_o.done_res       = 1'b1;
        exec_d               = EX_IDLE;
      end else if (item_i.kind == KIND_REG && exec_q == EX_REG_RMW) begin
        res_valid_o          = 1'b1;
        res_o.action         = ACT_DEV_READ;
        res_o.access_address = addr_q;
        src_d                = v;
        exec_d               = EX_DEV_RMW;
      end else if (item_i.kind == KIND_DEV && exec_q == EX_DEV_LOAD) begin
        res_valid_o    = 1'b1;
        res_o.action   = ACT_REG_WRITE;
        res_o.out_data = v;
        res_o.done_res = 1'b1;
        exec_d         = EX_IDLE;
      end else if (item_i.kind == KIND_DEV && exec_q == EX_DEV_RMW) begin
        res_valid_o          = 1'b1;
        res_o.action         = ACT_DEV_WRITE;
        res_o.access_address = addr_q;
        res_o.done_res       = 1'b1;
        case (opc_q)
          OP_ADD:  res_o.out_data = v + src_q;
          OP_OR:   res_o.out_data = v | src_q;
          OP_AND:  res_o.out_data = v & src_q;
          default: res_o.out_data = v ^ src_q;
        endcase
        exec_d = EX_IDLE;
      end
    end
  end

  // decoder state, updated once per consumed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= PH_PREFIX;
      exec_q  <= EX_IDLE;
      cnt_q   <= '0;
      rex_q   <= 1'b0;
      opc_q   <= '0;
      modrm_q <= '0;
      owed_q  <= '0;
      ae_q    <= '0;
      imm_q   <= '0;
      addr_q  <= '0;
      src_q   <= '0;
      ferr_q  <= ERR_NONE;
    end else if (fire_i) begin
      parse_q <= parse_d;
      exec_q  <= exec_d;
      cnt_q   <= cnt_d;
      rex_q   <= rex_d;
      opc_q   <= opc_d;
      modrm_q <= modrm_d;
      owed_q  <= owed_d;
      ae_q    <= ae_d;
      imm_q   <= imm_d;
      addr_q  <= addr_d;
      src_q   <= src_d;
      ferr_q  <= ferr_d;
    end
  end

endmodule

// File: rtl/core/x86_mmio_instruction_decode_apply.sv
// Top level of the x86 MMIO instruction decode and apply block.
// Holds the input register, the result register and the stream ports.
// Depends on mmiodec_pkg and mmiodec_core.
`timescale 1ns / 1ps

// Each item passes through the input register, where the decoder state machine
// handles it, and then through the result register. A new item is accepted
// every cycle as long as the result register is empty or being drained, so
// throughput is one item per cycle; the single decoder state update per cycle
// sets that figure. Instruction bytes (tuser kind 0) are sent with tlast on the
// final fetched byte; the block answers with a register read, device read,
// device write, register write or error, and expects register value (kind 1)
// or device data (kind 2) replies as the requests call for. Items that do not
// fit the current phase are dropped silently. A result with tlast high closes
// the instruction.

module x86_mmio_instruction_decode_apply #(
  parameter int unsigned MaxFetch = mmiodec_pkg::MAX_FETCH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] byte_value, [71:8] fault_address, [135:72] data_value
  input  logic [135:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser_i,
  // last_byte
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [3:0] reg_index, [67:4] access_address, [99:68] out_data,
  // [104:100] insn_length, [108:105] error_code, [111:109] zero
  output logic [111:0] m_axis_tdata_o,
  // [2:0] action
  output logic [2:0]   m_axis_tuser_o,
  // done_res
  output logic         m_axis_tlast_o
);
  import mmiodec_pkg::*;

  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;
  logic     out_valid_q, out_valid_d;
  res_t     out_res_q;
  logic     advance;
  logic     s_fire;
  logic     core_fire;
  logic     res_valid;
  res_t     res;

  // handshake control
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign core_fire       = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire)       in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = core_fire && res_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input item register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.kind          <= kind_e'(s_axis_tuser_i);
      in_item_q.byte_value    <= s_axis_tdata_i[7:0];
      in_item_q.last_byte     <= s_axis_tlast_i;
      in_item_q.fault_address <= s_axis_tdata_i[71:8];
      in_item_q.data_value    <= s_axis_tdata_i[135:72];
    end
  end

  mmiodec_core #(
    .MaxFetch(MaxFetch)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_item_q),
    .fire_i     (core_fire),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (core_fire && res_valid) out_res_q <= res;
  end

  // output packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.action;
  assign m_axis_tlast_o  = out_res_q.done_res;
  assign m_axis_tdata_o  = {3'b000, out_res_q.error_code, out_res_q.insn_length,
                            out_res_q.out_data, out_res_q.access_address,
                            out_res_q.reg_index};

  // error results always close the instruction and carry no length or register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ACT_ERROR |-> m_axis_tlast_o
      && m_axis_tdata_o[104:100] == 5'd0 && m_axis_tdata_o[3:0] == 4'd0)
    else $error("error result not closed or carries length/register");

  // non-error results carry no error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ACT_ERROR |-> m_axis_tdata_o[108:105] == 4'd0)
    else $error("error code on a non-error result");

  // input side only stalls behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a blocked result");

  // a consumed item that yields a result shows it in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_fire && res_valid |=> m_axis_tvalid_o)
    else $error("result lost between decoder and result register");

endmodule
